>>> hdl/ntcct_pkg.sv
package ntcct_pkg;

   localparam int unsigned TableEntriesDefault = 141;
   localparam int unsigned IndexWidth          = 8;
   localparam int unsigned CodeWidth           = 16;
   localparam int unsigned TempWidth           = 11;
   localparam int unsigned StatusWidth         = 2;
   localparam int unsigned ProductWidth        = 25;
   localparam int unsigned DivisorWidth        = 16;
   localparam int unsigned DivSteps            = ProductWidth;
   localparam int unsigned DivCountWidth       = $clog2(DivSteps);

   localparam logic [DivisorWidth:0]   HalfScale   = 17'd32768;
   localparam logic [ProductWidth-1:0] RatioScale  = 25'd1000;
   localparam logic [12:0]             IndexOffset = 13'd40;
   localparam logic [12:0]             DegreeScale = 13'd10;

   localparam logic signed [TempWidth-1:0] ColdTemp = -11'sd400;
   localparam logic signed [TempWidth-1:0] HotTemp  = 11'sd1000;

   localparam logic [StatusWidth-1:0] StatusInRange = 2'd0;
   localparam logic [StatusWidth-1:0] StatusCold    = 2'd1;
   localparam logic [StatusWidth-1:0] StatusHot     = 2'd2;

   // descending 10k ntc ratio table, entry i stands for (i - 40) degrees
   function automatic logic [15:0] ntc_rom_at(input logic [IndexWidth-1:0] idx);
      logic [15:0] r;
      case (idx)
         8'd0: r = 16'd20375;   8'd1: r = 16'd19204;   8'd2: r = 16'd18115;
         8'd3: r = 16'd17100;   8'd4: r = 16'd16152;   8'd5: r = 16'd15266;
         8'd6: r = 16'd14437;   8'd7: r = 16'd13661;   8'd8: r = 16'd12934;
         8'd9: r = 16'd12251;   8'd10: r = 16'd11611;  8'd11: r = 16'd11008;
         8'd12: r = 16'd10442;  8'd13: r = 16'd9909;   8'd14: r = 16'd9407;
         8'd15: r = 16'd8935;   8'd16: r = 16'd8489;   8'd17: r = 16'd8068;
         8'd18: r = 16'd7672;   8'd19: r = 16'd7297;   8'd20: r = 16'd6943;
         8'd21: r = 16'd6608;   8'd22: r = 16'd6292;   8'd23: r = 16'd5993;
         8'd24: r = 16'd5710;   8'd25: r = 16'd5442;   8'd26: r = 16'd5188;
         8'd27: r = 16'd4948;   8'd28: r = 16'd4720;   8'd29: r = 16'd4504;
         8'd30: r = 16'd4300;   8'd31: r = 16'd4105;   8'd32: r = 16'd3921;
         8'd33: r = 16'd3746;   8'd34: r = 16'd3580;   8'd35: r = 16'd3422;
         8'd36: r = 16'd3272;   8'd37: r = 16'd3130;   8'd38: r = 16'd2994;
         8'd39: r = 16'd2866;   8'd40: r = 16'd2751;   8'd41: r = 16'd2627;
         8'd42: r = 16'd2516;   8'd43: r = 16'd2410;   8'd44: r = 16'd2310;
         8'd45: r = 16'd2214;   8'd46: r = 16'd2123;   8'd47: r = 16'd2036;
         8'd48: r = 16'd1953;   8'd49: r = 16'd1874;   8'd50: r = 16'd1801;
         8'd51: r = 16'd1726;   8'd52: r = 16'd1658;   8'd53: r = 16'd1592;
         8'd54: r = 16'd1530;   8'd55: r = 16'd1470;   8'd56: r = 16'd1413;
         8'd57: r = 16'd1358;   8'd58: r = 16'd1306;   8'd59: r = 16'd1256;
         8'd60: r = 16'd1209;   8'd61: r = 16'd1163;   8'd62: r = 16'd1119;
         8'd63: r = 16'd1078;   8'd64: r = 16'd1038;   8'd65: r = 16'd1000;
         8'd66: r = 16'd963;    8'd67: r = 16'd928;    8'd68: r = 16'd894;
         8'd69: r = 16'd862;    8'd70: r = 16'd831;    8'd71: r = 16'd801;
         8'd72: r = 16'd773;    8'd73: r = 16'd746;    8'd74: r = 16'd719;
         8'd75: r = 16'd694;    8'd76: r = 16'd670;    8'd77: r = 16'd647;
         8'd78: r = 16'd625;    8'd79: r = 16'd604;    8'd80: r = 16'd583;
         8'd81: r = 16'd563;    8'd82: r = 16'd544;    8'd83: r = 16'd526;
         8'd84: r = 16'd509;    8'd85: r = 16'd492;    8'd86: r = 16'd476;
         8'd87: r = 16'd460;    8'd88: r = 16'd445;    8'd89: r = 16'd431;
         8'd90: r = 16'd416;    8'd91: r = 16'd403;    8'd92: r = 16'd390;
         8'd93: r = 16'd378;    8'd94: r = 16'd366;    8'd95: r = 16'd355;
         8'd96: r = 16'd343;    8'd97: r = 16'd333;    8'd98: r = 16'd322;
         8'd99: r = 16'd312;    8'd100: r = 16'd303;   8'd101: r = 16'd294;
         8'd102: r = 16'd285;   8'd103: r = 16'd276;   8'd104: r = 16'd268;
         8'd105: r = 16'd260;   8'd106: r = 16'd252;   8'd107: r = 16'd244;
         8'd108: r = 16'd237;   8'd109: r = 16'd230;   8'd110: r = 16'd224;
         8'd111: r = 16'd217;   8'd112: r = 16'd211;   8'd113: r = 16'd205;
         8'd114: r = 16'd199;   8'd115: r = 16'd193;   8'd116: r = 16'd188;
         8'd117: r = 16'd182;   8'd118: r = 16'd177;   8'd119: r = 16'd172;
         8'd120: r = 16'd167;   8'd121: r = 16'd163;   8'd122: r = 16'd158;
         8'd123: r = 16'd154;   8'd124: r = 16'd150;   8'd125: r = 16'd146;
         8'd126: r = 16'd142;   8'd127: r = 16'd138;   8'd128: r = 16'd134;
         8'd129: r = 16'd131;   8'd130: r = 16'd127;   8'd131: r = 16'd124;
         8'd132: r = 16'd120;   8'd133: r = 16'd117;   8'd134: r = 16'd114;
         8'd135: r = 16'd111;   8'd136: r = 16'd108;   8'd137: r = 16'd106;
         8'd138: r = 16'd103;   8'd139: r = 16'd100;   8'd140: r = 16'd98;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/ntc_code_to_temperature.sv
// Converts one 16-bit thermistor code into a temperature in tenths of a degree
// Celsius plus a range status. Pulse start with busy low to hand in a word.
// A code of half scale or more answers as cold in the cycle after it is taken. For
// any other code the accepting edge registers the code*1000 product and the
// divisor. After it come the start of the divider, 25 restoring steps that form
// the resistance ratio and the load of the search. Then an edge check against
// each end entry, up to eight binary search probes of the table through one
// comparator, a step to close the search and the registering of the result.
// The result word appears for exactly one cycle with rsp_valid high; the
// receiver cannot stall it and must take it in that cycle.
// busy is low again in that same cycle, so the next word may be started at once.
module ntc_code_to_temperature
   import ntcct_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [CodeWidth-1:0]        req_adc_code,
   output logic                        rsp_valid,
   output logic signed [TempWidth-1:0] rsp_temp_deci_c,
   output logic [StatusWidth-1:0]      rsp_range_status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_SEARCH
   } state_type;

   state_type                    state_ff;
   logic                         div_go_ff;
   logic [ProductWidth-1:0]      product_ff;
   logic [DivisorWidth-1:0]      divisor_ff;
   logic                         rsp_valid_ff;
   logic signed [TempWidth-1:0]  rsp_temp_ff;
   logic [StatusWidth-1:0]       rsp_status_ff;

   logic                         accept;
   logic [ProductWidth-1:0]      product_in;
   logic [DivisorWidth-1:0]      divisor_in;
   logic                         div_done;
   logic [ProductWidth-1:0]      ratio;
   logic                         search_done;
   logic signed [TempWidth-1:0]  search_temp;
   logic [StatusWidth-1:0]       search_status;

   assign accept     = start && (state_ff == S_IDLE);
   assign product_in = {{(ProductWidth-CodeWidth+1){1'b0}}, req_adc_code[CodeWidth-2:0]}
                       * RatioScale;
   assign divisor_in = DivisorWidth'(HalfScale - {1'b0, req_adc_code});

   ntcct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go_ff),
      .dividend (product_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (ratio)
   );

   ntcct_search #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_search (
      .clock  (clock),
      .reset  (reset),
      .go     (div_done),
      .ratio  (ratio),
      .done   (search_done),
      .temp   (search_temp),
      .status (search_status)
   );

   always_ff @(posedge clock) begin
      div_go_ff    <= 1'b0;
      rsp_valid_ff <= 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_adc_code[CodeWidth-1]) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_temp_ff   <= ColdTemp;
                  rsp_status_ff <= StatusCold;
               end else begin
                  product_ff <= product_in;
                  divisor_ff <= divisor_in;
                  div_go_ff  <= 1'b1;
                  state_ff   <= S_DIVIDE;
               end
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               state_ff <= S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (search_done) begin
               rsp_valid_ff  <= 1'b1;
               rsp_temp_ff   <= search_temp;
               rsp_status_ff <= search_status;
               state_ff      <= S_IDLE;
            end
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= S_IDLE;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temp_deci_c  = rsp_temp_ff;
   assign rsp_range_status = rsp_status_ff;

   // half scale codes answer cold on the next cycle
   a_cold_shortcut: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_adc_code[CodeWidth-1]
      |=> rsp_valid && rsp_range_status == StatusCold && rsp_temp_deci_c == ColdTemp)
      else $error("half scale code not answered cold");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_range_status == StatusInRange ||
                     rsp_range_status == StatusCold ||
                     rsp_range_status == StatusHot))
      else $error("bad range status");

   a_hot_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_status == StatusHot |-> rsp_temp_deci_c == HotTemp)
      else $error("hot clamp with wrong temperature");

   a_result_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word while still busy");

endmodule

>>> hdl/ntcct_div.sv
module ntcct_div
   import ntcct_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic [ProductWidth-1:0] dividend,
   input  logic [DivisorWidth-1:0] divisor,
   output logic                    done,
   output logic [ProductWidth-1:0] quotient
);

   logic                     run_ff;
   logic                     done_ff;
   logic [DivCountWidth-1:0] count_ff;
   logic [DivisorWidth-1:0]  divisor_ff;
   logic [DivisorWidth-1:0]  rem_ff;
   logic [ProductWidth-1:0]  quo_ff;

   logic [DivisorWidth:0]    trial;
   logic [DivisorWidth+1:0]  diff;
   logic                     borrow;
   logic [DivisorWidth-1:0]  rem_in;
   logic [ProductWidth-1:0]  quo_in;

   // one restoring step per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[ProductWidth-1]};
      diff   = {1'b0, trial} - {2'b00, divisor_ff};
      borrow = diff[DivisorWidth+1];
      rem_in = borrow ? trial[DivisorWidth-1:0] : diff[DivisorWidth-1:0];
      quo_in = {quo_ff[ProductWidth-2:0], ~borrow};
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (go) begin
         run_ff     <= 1'b1;
         count_ff   <= DivCountWidth'(DivSteps - 1);
         divisor_ff <= divisor;
         rem_ff     <= '0;
         quo_ff     <= dividend;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         if (count_ff == '0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/ntcct_search.sv
module ntcct_search
   import ntcct_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [ProductWidth-1:0]       ratio,
   output logic                          done,
   output logic signed [TempWidth-1:0]   temp,
   output logic [StatusWidth-1:0]        status
);

   localparam logic [IndexWidth-1:0] LastIdx = IndexWidth'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EDGE_LO,
      S_EDGE_HI,
      S_PROBE
   } state_type;

   state_type                    state_ff;
   logic [ProductWidth-1:0]      ratio_ff;
   logic [IndexWidth-1:0]        lo_ff;
   logic [IndexWidth-1:0]        hi_ff;
   logic                         done_ff;
   logic signed [TempWidth-1:0]  temp_ff;
   logic [StatusWidth-1:0]       status_ff;

   logic [IndexWidth-1:0]        mid;
   logic [IndexWidth-1:0]        sel_idx;
   logic [15:0]                  rom_val;
   logic                         ratio_gt;
   logic                         ratio_eq;
   logic                         span_open;
   logic [TempWidth-1:0]         temp_in;

   // single shared greater-than and equal compare against the selected table entry
   always_comb begin
      mid = IndexWidth'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
      case (state_ff)
         S_EDGE_LO: sel_idx = '0;
         S_EDGE_HI: sel_idx = LastIdx;
         default:   sel_idx = mid;
      endcase
      rom_val   = ntc_rom_at(sel_idx);
      ratio_gt  = ratio_ff > {{(ProductWidth-16){1'b0}}, rom_val};
      ratio_eq  = ratio_ff == {{(ProductWidth-16){1'b0}}, rom_val};
      span_open = {1'b0, hi_ff} > ({1'b0, lo_ff} + 1'b1);
      temp_in   = TempWidth'(({5'd0, lo_ff} - IndexOffset) * DegreeScale);
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (go) begin
               ratio_ff <= ratio;
               lo_ff    <= '0;
               hi_ff    <= LastIdx;
               state_ff <= S_EDGE_LO;
            end
         end
         S_EDGE_LO: begin
            if (ratio_gt || ratio_eq) begin
               done_ff   <= 1'b1;
               temp_ff   <= ColdTemp;
               status_ff <= StatusCold;
               state_ff  <= S_IDLE;
            end else begin
               state_ff <= S_EDGE_HI;
            end
         end
         S_EDGE_HI: begin
            if (!ratio_gt) begin
               done_ff   <= 1'b1;
               temp_ff   <= HotTemp;
               status_ff <= StatusHot;
               state_ff  <= S_IDLE;
            end else begin
               state_ff <= S_PROBE;
            end
         end
         S_PROBE: begin
            if (span_open) begin
               if (ratio_gt) begin
                  hi_ff <= mid;
               end else begin
                  lo_ff <= mid;
               end
            end else begin
               done_ff   <= 1'b1;
               temp_ff   <= temp_in;
               status_ff <= StatusInRange;
               state_ff  <= S_IDLE;
            end
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end
   end

   assign done   = done_ff;
   assign temp   = temp_ff;
   assign status = status_ff;

endmodule
